// ===== sv/pcmmix_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the PCM playback mixer.
// No dependencies.
package pcmmix_pkg;

	localparam int NUM_CHANNELS_DEF  = 16;
	localparam int ROM_ADDR_BITS_DEF = 20;
	localparam int MIX_W             = 26;
	localparam int ACC_W             = 32;
	localparam int MUL_A_W           = 26;
	localparam int MUL_B_W           = 10;
	localparam int MUL_P_W           = MUL_A_W + MUL_B_W;
	localparam int CFG_ADDR_W        = 8;
	localparam int CFG_DATA_W        = 8;

	localparam logic [7:0] STATUS_READY = 8'h80;
	localparam logic [7:0] CMD_PAN_BASE = 8'h80;
	localparam logic [7:0] CMD_LIMIT    = 8'h90;
	localparam logic [5:0] PAN_CENTER   = 6'd32;
	localparam logic [15:0] PAN_BIAS    = 16'h0010;

	typedef enum logic [2:0] {
		OP_DATA_HI = 3'd0,
		OP_DATA_LO = 3'd1,
		OP_COMMAND = 3'd2,
		OP_TICK    = 3'd3,
		OP_ROM     = 3'd4,
		OP_STATUS  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		REG_BANK  = 3'd0,
		REG_START = 3'd1,
		REG_PITCH = 3'd2,
		REG_LOOP  = 3'd4,
		REG_END   = 3'd5,
		REG_VOL   = 3'd6
	} chan_reg_t;

	localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_SHIFT = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_RATE_MODE    = 8'd1;

	localparam logic [8:0] PAN_GAIN [33] = '{
		9'd0,   9'd45,  9'd64,  9'd78,  9'd90,  9'd101, 9'd110, 9'd119,
		9'd128, 9'd135, 9'd143, 9'd150, 9'd156, 9'd163, 9'd169, 9'd175,
		9'd181, 9'd186, 9'd191, 9'd197, 9'd202, 9'd207, 9'd212, 9'd217,
		9'd221, 9'd226, 9'd230, 9'd235, 9'd239, 9'd243, 9'd247, 9'd251,
		9'd256
	};

	function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'((64'sd1 <<< (MIX_W - 1)) - 64'sd1);
		lo = -ACC_W'(64'sd1 <<< (MIX_W - 1));
		if (v > hi)
			return hi[MIX_W-1:0];
		else if (v < lo)
			return lo[MIX_W-1:0];
		else
			return v[MIX_W-1:0];
	endfunction

endpackage

// ===== sv/pcmmix_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces: input items, result items, configuration writes.
// Depends on pcmmix_pkg.
interface pcmmix_item_if import pcmmix_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [7:0]  byte_value;
	logic [22:0] rom_address;
	modport source (output valid, operation, byte_value, rom_address, input ready);
	modport sink (input valid, operation, byte_value, rom_address, output ready);
endinterface

interface pcmmix_result_if import pcmmix_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    result_kind;
	logic signed [MIX_W-1:0] left_mix;
	logic signed [MIX_W-1:0] right_mix;
	logic [7:0]              status_byte;
	modport source (output valid, result_kind, left_mix, right_mix, status_byte, input ready);
	modport sink (input valid, result_kind, left_mix, right_mix, status_byte, output ready);
endinterface

interface pcmmix_cfg_if import pcmmix_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ===== sv/pcmmix_sample_playback_mixer.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Moves
// item    | in  | operation, byte_value, rom_address
// result  | out | result_kind, left_mix, right_mix, status_byte
// cfg     | in  | addr (0 volume_shift, 1 rate_mode), data; always ready
// Register writes, data and ROM loads go from the exec state back to idle; a status read goes on to emit.
// A tick steps through the channels in turn: an idle one is skipped, a keyed one takes the ROM read
// and four products of the shared multiplier; the mix then goes on to emit.
// Reset clears all channel state; sample ROM is not cleared.
// A finished result waits in the output register; new items are taken meanwhile.
// Depends on pcmmix_pkg, pcmmix_if, pcmmix_ram, pcmmix_mul.
module pcm_sample_playback_mixer import pcmmix_pkg::*; #(
	parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	pcmmix_item_if.sink   item,
	pcmmix_result_if.source result,
	pcmmix_cfg_if.sink    cfg
);
	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_CHAN, S_ROM, S_VL, S_SL, S_VR, S_SR, S_ACC, S_EMIT
	} state_t;

	state_t state_q;
	logic [2:0]  op_q;
	logic [7:0]  byte_q;
	logic [22:0] addr_in_q;
	logic [2:0]  vshift_q;
	logic        rate_q;
	logic [15:0] latch_q;
	logic [CNT_W-1:0] cnt_q;
	logic fetch_q;
	logic signed [ACC_W-1:0] acc_l_q, acc_r_q;

	logic [6:0]  bank_q   [NUM_CHANNELS];
	logic [16:0] addr_q   [NUM_CHANNELS];
	logic [19:0] pitch_q  [NUM_CHANNELS];
	logic [15:0] loop_q   [NUM_CHANNELS];
	logic [15:0] end_q    [NUM_CHANNELS];
	logic [15:0] vol_q    [NUM_CHANNELS];
	logic        keyed_q  [NUM_CHANNELS];
	logic [8:0]  lgain_q  [NUM_CHANNELS];
	logic [8:0]  rgain_q  [NUM_CHANNELS];
	logic [7:0]  last_q   [NUM_CHANNELS];
	logic [20:0] phase_q  [NUM_CHANNELS];

	// finished result before it moves into the output register
	logic                    res_kind_q;
	logic signed [MIX_W-1:0] res_l_q, res_r_q;
	logic [7:0]              res_status_q;

	logic                    out_valid_q;
	logic                    out_kind_q;
	logic signed [MIX_W-1:0] out_l_q, out_r_q;
	logic [7:0]              out_status_q;

	// command decode
	logic [3:0] cmd_ch;
	logic [2:0] cmd_reg;
	logic       cmd_pan, cmd_ok;
	always_comb begin
		cmd_pan = (byte_q >= CMD_PAN_BASE);
		cmd_reg = cmd_pan ? 3'd7 : byte_q[2:0];
		cmd_ch  = cmd_pan ? byte_q[3:0] : byte_q[6:3];
		if (!cmd_pan && cmd_reg == REG_BANK)
			cmd_ch = cmd_ch + 4'd1;
		cmd_ok = (byte_q < CMD_LIMIT) && (5'(cmd_ch) < 5'(NUM_CHANNELS));
	end

	logic [IDX_W-1:0] idx;
	assign idx = (state_q == S_EXEC) ? cmd_ch[IDX_W-1:0] : cnt_q[IDX_W-1:0];

	// tick step of the current channel
	logic [4:0]  step_cnt;
	logic [16:0] step_addr, new_addr;
	logic        hit_end;
	logic [15:0] loop_addr;
	logic [23:0] rom_sum;
	always_comb begin
		step_cnt  = phase_q[idx][20:16];
		step_addr = addr_q[idx] + 17'(step_cnt);
		hit_end   = step_addr >= {1'b0, end_q[idx]};
		loop_addr = end_q[idx] - loop_q[idx];
		new_addr  = hit_end ? {1'b0, loop_addr} : step_addr;
		rom_sum   = {1'b0, bank_q[idx], 16'h0000} + 24'(new_addr);
	end

	// pan decode
	logic [15:0] pan_raw;
	logic [5:0]  pan_d;
	assign pan_raw = latch_q - PAN_BIAS;
	assign pan_d   = (pan_raw[5:0] > PAN_CENTER) ? PAN_CENTER : pan_raw[5:0];

	// sample ROM
	logic                     rom_we;
	logic [ROM_ADDR_BITS-1:0] rom_addr;
	logic [7:0]               rom_rdata;
	assign rom_we   = (state_q == S_EXEC) && (op_q == OP_ROM);
	assign rom_addr = rom_we ? addr_in_q[ROM_ADDR_BITS-1:0] : rom_sum[ROM_ADDR_BITS-1:0];

	pcmmix_ram #(.WIDTH(8), .DEPTH(2 ** ROM_ADDR_BITS)) u_rom (
		.clk  (clk),
		.we   (rom_we),
		.addr (rom_addr),
		.wdata(byte_q),
		.rdata(rom_rdata)
	);

	// shared multiplier: gain*volume, then sample*scaled gain, per side
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_s1;
	logic [24:0] scaled;
	assign scaled = prod_s1[24:0] >> vshift_q;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_VL: begin
				mul_a = MUL_A_W'(vol_q[idx]);
				mul_b = MUL_B_W'(lgain_q[idx]);
			end
			S_VR: begin
				mul_a = MUL_A_W'(vol_q[idx]);
				mul_b = MUL_B_W'(rgain_q[idx]);
			end
			S_SL, S_SR: begin
				mul_a = {1'b0, scaled};
				mul_b = MUL_B_W'($signed(last_q[idx]));
			end
			default: ;
		endcase
	end

	pcmmix_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_s1(prod_s1));

	logic signed [ACC_W-1:0] term;
	assign term = ACC_W'(prod_s1 >>> 6);

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.left_mix    = out_l_q;
	assign result.right_mix   = out_r_q;
	assign result.status_byte = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vshift_q     <= 3'd6;
			rate_q       <= 1'b0;
			latch_q      <= '0;
			cnt_q        <= '0;
			fetch_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= 1'b0;
			out_l_q      <= '0;
			out_r_q      <= '0;
			out_status_q <= '0;
			res_kind_q   <= 1'b0;
			res_l_q      <= '0;
			res_r_q      <= '0;
			res_status_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				bank_q[i]  <= '0;
				addr_q[i]  <= '0;
				pitch_q[i] <= '0;
				loop_q[i]  <= '0;
				end_q[i]   <= '0;
				vol_q[i]   <= '0;
				keyed_q[i] <= 1'b0;
				lgain_q[i] <= '0;
				rgain_q[i] <= '0;
				last_q[i]  <= '0;
				phase_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				if (cfg.addr == CFG_VOLUME_SHIFT)
					vshift_q <= cfg.data[2:0];
				else if (cfg.addr == CFG_RATE_MODE)
					rate_q <= cfg.data[0];
			end
			// emit state reloads the output register itself
			if (result.ready && state_q != S_EMIT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						op_q      <= item.operation;
						byte_q    <= item.byte_value;
						addr_in_q <= item.rom_address;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= (op_q == OP_TICK) ? S_CHAN :
						(op_q == OP_STATUS) ? S_EMIT : S_IDLE;
					case (op_q)
						OP_DATA_HI: latch_q[15:8] <= byte_q;
						OP_DATA_LO: latch_q[7:0]  <= byte_q;
						OP_TICK: begin
							cnt_q   <= '0;
							acc_l_q <= '0;
							acc_r_q <= '0;
						end
						OP_STATUS: begin
							res_kind_q   <= 1'b1;
							res_l_q      <= '0;
							res_r_q      <= '0;
							res_status_q <= STATUS_READY;
						end
						OP_COMMAND: begin
							if (cmd_ok) begin
								if (cmd_pan) begin
									latch_q      <= 16'(pan_d);
									rgain_q[idx] <= PAN_GAIN[pan_d];
									lgain_q[idx] <= PAN_GAIN[PAN_CENTER - pan_d];
								end else begin
									case (cmd_reg)
										REG_BANK:  bank_q[idx] <= latch_q[6:0];
										REG_START: addr_q[idx] <= 17'(latch_q);
										REG_PITCH: begin
											pitch_q[idx] <= rate_q ? {1'b0, latch_q, 3'b000}
												: {latch_q, 4'b0000};
											if (latch_q == '0)
												keyed_q[idx] <= 1'b0;
										end
										REG_LOOP: loop_q[idx] <= latch_q;
										REG_END:  end_q[idx]  <= latch_q;
										REG_VOL: begin
											vol_q[idx] <= latch_q;
											if (latch_q == '0) begin
												keyed_q[idx] <= 1'b0;
											end else if (!keyed_q[idx]) begin
												keyed_q[idx] <= 1'b1;
												phase_q[idx] <= '0;
												last_q[idx]  <= '0;
											end
										end
										default: ;
									endcase
								end
							end
						end
						default: ;
					endcase
				end
				S_CHAN: begin
					if (cnt_q == CNT_W'(NUM_CHANNELS)) begin
						res_kind_q   <= 1'b0;
						res_l_q      <= sat_mix(acc_l_q);
						res_r_q      <= sat_mix(acc_r_q);
						res_status_q <= '0;
						state_q      <= S_EMIT;
					end else if (!keyed_q[idx]) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						phase_q[idx] <= {5'b0, phase_q[idx][15:0]};
						if (step_cnt != '0 && hit_end && loop_q[idx] == '0) begin
							// ran off the end with no loop: key off, no contribution
							addr_q[idx]  <= step_addr;
							keyed_q[idx] <= 1'b0;
							cnt_q        <= cnt_q + 1'b1;
						end else begin
							if (step_cnt != '0)
								addr_q[idx] <= new_addr;
							fetch_q <= (step_cnt != '0);
							state_q <= S_ROM;
						end
					end
				end
				S_ROM: begin
					if (fetch_q)
						last_q[idx] <= rom_rdata;
					state_q <= S_VL;
				end
				S_VL: state_q <= S_SL;
				S_SL: state_q <= S_VR;
				S_VR: begin
					acc_l_q <= acc_l_q + term;
					state_q <= S_SR;
				end
				S_SR: state_q <= S_ACC;
				S_ACC: begin
					acc_r_q      <= acc_r_q + term;
					phase_q[idx] <= phase_q[idx] + 21'(pitch_q[idx]);
					cnt_q        <= cnt_q + 1'b1;
					state_q      <= S_CHAN;
				end
				S_EMIT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= res_kind_q;
						out_l_q      <= res_l_q;
						out_r_q      <= res_r_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item taken while busy");

	a_status_value: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.result_kind |->
			result.status_byte == STATUS_READY && result.left_mix == '0)
		else $error("bad status item");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_CHANNELS))
		else $error("channel counter out of range");

	a_emit_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result raised outside emit");
endmodule

// ===== sv/pcmmix_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module pcmmix_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== sv/pcmmix_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Depends on pcmmix_pkg.
module pcmmix_mul import pcmmix_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_s1
);
	always_ff @(posedge clk) begin
		p_s1 <= MUL_P_W'(a) * MUL_P_W'(b);
	end
endmodule
